// ===== rtl/spq_pkg.sv =====
// spq_pkg: shared types and codes for the sorted priority queue
// used by spq_cell and sorted_priority_queue; no dependencies
package spq_pkg;

    localparam int PRI_BITS = 16;

    // request opcodes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE       = 2'd0,
        ST_EMPTY      = 2'd1,
        ST_FULL_DROP  = 2'd2
    } status_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic                       ins;
        logic                       rem;
        logic signed [PRI_BITS-1:0] pri;
    } spq_ctl_t;

endpackage

// ===== rtl/spq_cell.sv =====
// spq_cell: one slot of the sorted chain, holds a priority and a payload
// depends on spq_pkg
module spq_cell
    import spq_pkg::*;
#(
    parameter int IDX          = 0,
    parameter int CW           = 5,
    parameter int PAYLOAD_BITS = 64
)
(
    input  logic                       clk,
    input  spq_ctl_t                   ctl,
    input  logic [PAYLOAD_BITS-1:0]    new_payload,
    input  logic [CW-1:0]              count,
    input  logic                       left_keep,
    input  logic signed [PRI_BITS-1:0] left_pri,
    input  logic [PAYLOAD_BITS-1:0]    left_payload,
    input  logic signed [PRI_BITS-1:0] right_pri,
    input  logic [PAYLOAD_BITS-1:0]    right_payload,
    output logic                       keep,
    output logic signed [PRI_BITS-1:0] pri,
    output logic [PAYLOAD_BITS-1:0]    payload
);

    logic signed [PRI_BITS-1:0] pri_reg;
    logic signed [PRI_BITS-1:0] pri_next;
    logic [PAYLOAD_BITS-1:0]    payload_reg;
    logic [PAYLOAD_BITS-1:0]    payload_next;
    logic                       valid;

    assign valid = CW'(IDX) < count;
    // entry stays put when it sorts strictly ahead of the new one
    assign keep  = valid && (pri_reg < ctl.pri);

    always_comb
    begin
        pri_next     = pri_reg;
        payload_next = payload_reg;
        if (ctl.ins)
        begin
            if (!keep)
            begin
                if (left_keep)
                begin
                    pri_next     = ctl.pri;
                    payload_next = new_payload;
                end
                else
                begin
                    pri_next     = left_pri;
                    payload_next = left_payload;
                end
            end
        end
        else if (ctl.rem)
        begin
            pri_next     = right_pri;
            payload_next = right_payload;
        end
    end

    always_ff @(posedge clk)
    begin
        pri_reg     <= pri_next;
        payload_reg <= payload_next;
    end

    assign pri     = pri_reg;
    assign payload = payload_reg;

endmodule

// ===== rtl/sorted_priority_queue.sv =====
// sorted_priority_queue: top level, a chain of spq_cell slots kept in order
// depends on spq_pkg and spq_cell
//
// Bounded min-first priority queue. A request is taken on any rising edge
// with start high; busy is always low, so one request is taken every clock
// cycle. Each request gives exactly one result, shown for one cycle with done
// high in the cycle right after the request; the receiver cannot stall, so it
// must take the result in that cycle. The chain of cells updates all slots in
// the same edge: on insert each slot compares its own priority with the new
// one and either holds, takes the new entry, or takes its left neighbor's;
// on remove every slot takes its right neighbor's. Among equal priorities the
// newest entry leaves first. A remove on an empty queue reports an empty
// status, an insert into a full queue is dropped and flagged. Slot contents
// are not reset; only the entry count and done are.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH        = 16,
    parameter int PAYLOAD_BITS = 64
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       opcode,
    input  logic signed [PRI_BITS-1:0] priority_req,
    input  logic [PAYLOAD_BITS-1:0]    payload,
    output logic                       done,
    output logic [1:0]                 status,
    output logic [PAYLOAD_BITS-1:0]    removed_payload,
    output logic signed [PRI_BITS-1:0] removed_priority,
    output logic [4:0]                 occupancy,
    output logic                       head_valid,
    output logic [PAYLOAD_BITS-1:0]    head_payload
);

    localparam int CW = $clog2(DEPTH + 1);

    logic                       done_reg;
    status_t                    status_reg;
    status_t                    status_next;
    logic [PAYLOAD_BITS-1:0]    rem_pay_reg;
    logic [PAYLOAD_BITS-1:0]    rem_pay_next;
    logic signed [PRI_BITS-1:0] rem_pri_reg;
    logic signed [PRI_BITS-1:0] rem_pri_next;
    logic [CW-1:0]              count_reg;
    logic [CW-1:0]              count_next;
    logic [CW+4:0]              count_ext;

    spq_ctl_t                   ctl;
    logic                       is_full;
    logic                       is_empty;

    logic                       cell_keep [DEPTH];
    logic signed [PRI_BITS-1:0] cell_pri  [DEPTH];
    logic [PAYLOAD_BITS-1:0]    cell_pay  [DEPTH];

    assign busy     = 1'b0;
    assign is_full  = count_reg == CW'(DEPTH);
    assign is_empty = count_reg == '0;

    // command broadcast to the whole chain
    always_comb
    begin
        ctl.ins = start && (opcode == OP_INSERT) && !is_full;
        ctl.rem = start && (opcode == OP_REMOVE) && !is_empty;
        ctl.pri = priority_req;
    end

    // result capture and count update
    always_comb
    begin
        status_next  = ST_DONE;
        rem_pay_next = '0;
        rem_pri_next = '0;
        count_next   = count_reg;
        if (opcode == OP_INSERT)
        begin
            if (is_full)
            begin
                status_next = ST_FULL_DROP;
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
        end
        else
        begin
            if (is_empty)
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                // head is read before the chain shifts
                rem_pay_next = cell_pay[0];
                rem_pri_next = cell_pri[0];
                count_next   = count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= start;
            if (start)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            status_reg  <= status_next;
            rem_pay_reg <= rem_pay_next;
            rem_pri_reg <= rem_pri_next;
        end
    end

    // the chain: slot 0 is the head
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic                       l_keep;
        logic signed [PRI_BITS-1:0] l_pri;
        logic [PAYLOAD_BITS-1:0]    l_pay;
        logic signed [PRI_BITS-1:0] r_pri;
        logic [PAYLOAD_BITS-1:0]    r_pay;

        if (i == 0)
        begin : g_first
            // nothing ahead of the head, so it takes the new entry directly
            assign l_keep = 1'b1;
            assign l_pri  = '0;
            assign l_pay  = '0;
        end
        else
        begin : g_mid
            assign l_keep = cell_keep[i-1];
            assign l_pri  = cell_pri[i-1];
            assign l_pay  = cell_pay[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            // slot past the end is unused after a remove
            assign r_pri = '0;
            assign r_pay = '0;
        end
        else
        begin : g_inner
            assign r_pri = cell_pri[i+1];
            assign r_pay = cell_pay[i+1];
        end

        spq_cell #(
            .IDX          (i),
            .CW           (CW),
            .PAYLOAD_BITS (PAYLOAD_BITS)
        ) u_cell (
            .clk           (clk),
            .ctl           (ctl),
            .new_payload   (payload),
            .count         (count_reg),
            .left_keep     (l_keep),
            .left_pri      (l_pri),
            .left_payload  (l_pay),
            .right_pri     (r_pri),
            .right_payload (r_pay),
            .keep          (cell_keep[i]),
            .pri           (cell_pri[i]),
            .payload       (cell_pay[i])
        );
    end

    // outputs, valid while done is high
    assign count_ext        = {5'd0, count_reg};
    assign done             = done_reg;
    assign status           = status_reg;
    assign removed_payload  = rem_pay_reg;
    assign removed_priority = rem_pri_reg;
    assign occupancy        = count_ext[4:0];
    assign head_valid       = !is_empty;
    assign head_payload     = is_empty ? '0 : cell_pay[0];

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// testbench for sorted_priority_queue: directed and random insert/remove requests
// checked field by field against an in-bench model of the sorted queue
// depends on spq_pkg and the sorted_priority_queue rtl
module testbench;
    import spq_pkg::*;

    localparam int QDEPTH   = 16;
    localparam int PAY_BITS = 64;

    // one request as the driver applies it
    typedef struct {
        logic                       op;
        logic signed [PRI_BITS-1:0] pri;
        logic [PAY_BITS-1:0]        pay;
        logic                       drain;   // hold off until every result is back
    } req_t;

    // one result as the block should report it
    typedef struct {
        status_t                    status;
        logic [PAY_BITS-1:0]        rem_pay;
        logic signed [PRI_BITS-1:0] rem_pri;
        logic [4:0]                 occ;
        logic                       head_valid;
        logic [PAY_BITS-1:0]        head_pay;
    } result_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic                       opcode = 1'b0;
    logic signed [PRI_BITS-1:0] priority_req = '0;
    logic [PAY_BITS-1:0]        payload = '0;
    logic                       done;
    logic [1:0]                 status;
    logic [PAY_BITS-1:0]        removed_payload;
    logic signed [PRI_BITS-1:0] removed_priority;
    logic [4:0]                 occupancy;
    logic                       head_valid;
    logic [PAY_BITS-1:0]        head_payload;

    sorted_priority_queue #(
        .DEPTH        (QDEPTH),
        .PAYLOAD_BITS (PAY_BITS)
    ) u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .opcode           (opcode),
        .priority_req     (priority_req),
        .payload          (payload),
        .done             (done),
        .status           (status),
        .removed_payload  (removed_payload),
        .removed_priority (removed_priority),
        .occupancy        (occupancy),
        .head_valid       (head_valid),
        .head_payload     (head_payload)
    );

    always #2 clk = ~clk;

    // requests not yet driven, and results predicted but not yet seen
    req_t    pending_requests[$];
    result_t expected_results[$];

    int total_requests  = 0;
    int requests_taken  = 0;   // owned by the driver
    int results_checked = 0;   // owned by the monitor, updated nonblocking
    int mismatch_count  = 0;

    // model of the queue contents, head at slot 0
    logic [PAY_BITS-1:0]        model_pay [QDEPTH];
    logic signed [PRI_BITS-1:0] model_pri [QDEPTH];
    int                         model_count = 0;

    // driver burst shaping
    req_t active_req;
    int   burst_left = 1;
    int   gap_left   = 0;

    function automatic void add_request(input logic op, input logic signed [PRI_BITS-1:0] pri,
                                        input logic [PAY_BITS-1:0] pay, input logic drain);
        req_t r;
        r.op    = op;
        r.pri   = pri;
        r.pay   = pay;
        r.drain = drain;
        pending_requests.push_back(r);
    endfunction

    // apply one request to the model and give the result it should produce
    task automatic predict_queue_result(input req_t r, output result_t res);
        int pos;
        int i;
        res.status  = ST_DONE;
        res.rem_pay = '0;
        res.rem_pri = '0;
        if (r.op == OP_INSERT) begin
            if (model_count >= QDEPTH) begin
                // full queue: request dropped, contents untouched
                res.status = ST_FULL_DROP;
            end else begin
                // new entry goes ahead of the first entry with priority >= its own,
                // so the newest of equal priorities leaves first
                pos = 0;
                while (pos < model_count && model_pri[pos] < r.pri)
                    pos++;
                for (i = model_count; i > pos; i--) begin
                    model_pay[i] = model_pay[i-1];
                    model_pri[i] = model_pri[i-1];
                end
                model_pay[pos] = r.pay;
                model_pri[pos] = r.pri;
                model_count++;
            end
        end else begin
            if (model_count == 0) begin
                // remove on empty queue: nothing changes
                res.status = ST_EMPTY;
            end else begin
                res.rem_pay = model_pay[0];
                res.rem_pri = model_pri[0];
                for (i = 1; i < model_count; i++) begin
                    model_pay[i-1] = model_pay[i];
                    model_pri[i-1] = model_pri[i];
                end
                model_count--;
            end
        end
        res.occ        = model_count[4:0];
        res.head_valid = (model_count > 0);
        res.head_pay   = (model_count > 0) ? model_pay[0] : '0;
    endtask

    // driver: predicts on every accepted request, then picks what to drive next
    always @(posedge clk) begin
        result_t res;
        if (!rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                predict_queue_result(active_req, res);
                expected_results.push_back(res);
                requests_taken++;
            end
            // a request held off by busy keeps its values and start
            if (!(start && busy)) begin
                if (gap_left > 0) begin
                    // idle gap between bursts
                    gap_left--;
                    start <= 1'b0;
                end else if (pending_requests.size() == 0) begin
                    start <= 1'b0;
                end else if (pending_requests[0].drain && requests_taken != results_checked) begin
                    // pause until the queue of expected results has run dry
                    start <= 1'b0;
                end else begin
                    active_req = pending_requests.pop_front();
                    opcode       <= active_req.op;
                    priority_req <= active_req.pri;
                    payload      <= active_req.pay;
                    start        <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        // new burst; some bursts run back to back with no gap
                        burst_left = $urandom_range(1, 48);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // monitor: every done strobe is checked against the oldest expectation
    always @(posedge clk) begin
        result_t exp_res;
        if (rst_n && done) begin
            if (expected_results.size() == 0) begin
                $error("result with no request outstanding");
                mismatch_count++;
            end else begin
                exp_res = expected_results.pop_front();
                if (status !== exp_res.status) begin
                    $error("status: expected %0d, got %0d", exp_res.status, status);
                    mismatch_count++;
                end
                if (removed_payload !== exp_res.rem_pay) begin
                    $error("removed_payload: expected %h, got %h", exp_res.rem_pay,
                           removed_payload);
                    mismatch_count++;
                end
                if (removed_priority !== exp_res.rem_pri) begin
                    $error("removed_priority: expected %0d, got %0d", exp_res.rem_pri,
                           removed_priority);
                    mismatch_count++;
                end
                if (occupancy !== exp_res.occ) begin
                    $error("occupancy: expected %0d, got %0d", exp_res.occ, occupancy);
                    mismatch_count++;
                end
                if (head_valid !== exp_res.head_valid) begin
                    $error("head_valid: expected %0d, got %0d", exp_res.head_valid, head_valid);
                    mismatch_count++;
                end
                if (head_payload !== exp_res.head_pay) begin
                    $error("head_payload: expected %h, got %h", exp_res.head_pay, head_payload);
                    mismatch_count++;
                end
            end
            results_checked <= results_checked + 1;
        end
    end

    // stimulus, reset and end of run
    initial begin
        int                         seg;
        int                         n;
        int                         insert_pct;
        int                         pick;
        logic                       op;
        logic signed [PRI_BITS-1:0] pri;
        logic [PAY_BITS-1:0]        pay;
        logic                       drain;

        // directed: remove on empty queue first
        add_request(OP_REMOVE, 16'sd0, 64'd0, 1'b0);
        // priority and payload extremes, then three equal priorities
        add_request(OP_INSERT, 16'sh7fff, '1, 1'b0);
        add_request(OP_INSERT, 16'sh8000, 64'd0, 1'b0);
        add_request(OP_INSERT, 16'sd0, 64'haaaa_aaaa_aaaa_aaaa, 1'b0);
        add_request(OP_INSERT, 16'sd0, 64'h5555_5555_5555_5555, 1'b0);
        add_request(OP_INSERT, 16'sd0, 64'h0123_4567_89ab_cdef, 1'b0);
        // fill the rest of the queue with clustered priorities
        for (n = 0; n < 11; n++) begin
            pri = 16'(n % 3) - 16'd1;
            add_request(OP_INSERT, pri, {32'(n), ~32'(n)}, 1'b0);
        end
        // insert into a full queue, with a priority that would become the head
        add_request(OP_INSERT, 16'sh8000, '1, 1'b0);
        // removes from a full queue, the first after a full drain
        add_request(OP_REMOVE, 16'sh7fff, '1, 1'b1);
        for (n = 0; n < 5; n++)
            add_request(OP_REMOVE, 16'sd0, 64'd0, 1'b0);

        // random segments, most leaning toward inserts or removes so the
        // queue swings between full and empty
        for (seg = 0; seg < 15; seg++) begin
            case (seg % 6)
                0:       insert_pct = 90;
                1:       insert_pct = 10;
                2:       insert_pct = 70;
                3:       insert_pct = 30;
                4:       insert_pct = 95;
                default: insert_pct = 50;
            endcase
            for (n = 0; n < 75; n++) begin
                op   = ($urandom_range(1, 100) <= insert_pct) ? OP_INSERT : OP_REMOVE;
                pick = $urandom_range(0, 3);
                if (pick == 0) begin
                    // narrow range for plenty of equal priorities
                    pri = 16'($urandom_range(0, 6)) - 16'd3;
                end else if (pick == 3) begin
                    case ($urandom_range(0, 3))
                        0:       pri = 16'sh8000;
                        1:       pri = 16'sh7fff;
                        2:       pri = -16'sd1;
                        default: pri = 16'sd0;
                    endcase
                end else begin
                    pri = 16'($urandom);
                end
                if ($urandom_range(0, 15) == 0)
                    pay = $urandom_range(0, 1) ? '1 : '0;
                else
                    pay = {$urandom, $urandom};
                drain = (n == 0) && ((seg % 4 == 0) || ($urandom_range(0, 3) == 0));
                add_request(op, pri, pay, drain);
            end
        end
        total_requests = pending_requests.size();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // every request must come back with a result
        while (results_checked < total_requests)
            @(posedge clk);
        // the result follows the request in the next cycle; leave room for strays
        repeat (8) @(posedge clk);
        if (expected_results.size() != 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
